[rtl/otlr_pkg.sv]
// Shared types, constants and font tables for the OLED text line renderer.
`default_nettype none
package otlr_pkg;

	localparam int LINE_COLUMNS_DEF = 128;
	localparam logic [7:0] ADDR_RESET = 8'h78;

	localparam int CELL_COLS  = 6;
	localparam int GLYPH_COLS = 5;
	localparam int HDR_BYTES  = 11;
	localparam int MAX_PAGE   = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CTRL_CMD    = 8'h00;
	localparam logic [7:0] CTRL_DATA   = 8'h40;
	localparam logic [7:0] PAGE_CMD    = 8'hB0;
	localparam logic [7:0] COL_LO_CMD  = 8'h00;
	localparam logic [7:0] COL_HI_CMD  = 8'h10;
	localparam logic [7:0] BLANK_COL   = 8'h00;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_UPZ   = 8'h5A;

	// glyph codes: digits 0..9, capitals 10..35, then the specials
	localparam logic [5:0] GL_LETTER_BASE = 6'd10;
	localparam logic [5:0] GL_COLON = 6'd36;
	localparam logic [5:0] GL_DASH  = 6'd37;
	localparam logic [5:0] GL_SPACE = 6'd38;
	localparam logic [5:0] GL_QUERY = 6'd39;

	// one queued cell: what the back end needs to emit its beats
	typedef struct packed {
		logic       hdr;     // emit positioning + data header first
		logic [2:0] page;
		logic [5:0] glyph;
		logic [2:0] ncols;   // 1..6 columns
		logic       final_c; // last cell of the line, stop after it
	} cell_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [5:0] glyph_code(logic [7:0] ch);
		logic [5:0] g;
		if (ch >= CH_ZERO && ch <= CH_NINE)
			g = 6'(ch - CH_ZERO);
		else if (ch >= CH_UPA && ch <= CH_UPZ)
			g = 6'(ch - CH_UPA) + GL_LETTER_BASE;
		else if (ch == CH_COLON)
			g = GL_COLON;
		else if (ch == CH_DASH)
			g = GL_DASH;
		else if (ch == CH_SPACE)
			g = GL_SPACE;
		else
			g = GL_QUERY;
		return g;
	endfunction

	// column 0 sits in the top byte
	function automatic logic [7:0] font_column(logic [5:0] glyph, logic [2:0] col);
		logic [39:0] row;
		logic [7:0]  c;
		case (glyph)
			6'd0:  row = 40'h3E_51_49_45_3E;
			6'd1:  row = 40'h00_42_7F_40_00;
			6'd2:  row = 40'h42_61_51_49_46;
			6'd3:  row = 40'h21_41_45_4B_31;
			6'd4:  row = 40'h18_14_12_7F_10;
			6'd5:  row = 40'h27_45_45_45_39;
			6'd6:  row = 40'h3C_4A_49_49_30;
			6'd7:  row = 40'h01_71_09_05_03;
			6'd8:  row = 40'h36_49_49_49_36;
			6'd9:  row = 40'h06_49_49_29_1E;
			6'd10: row = 40'h7E_11_11_11_7E;
			6'd11: row = 40'h7F_49_49_49_36;
			6'd12: row = 40'h3E_41_41_41_22;
			6'd13: row = 40'h7F_41_41_22_1C;
			6'd14: row = 40'h7F_49_49_49_41;
			6'd15: row = 40'h7F_09_09_09_01;
			6'd16: row = 40'h3E_41_49_49_7A;
			6'd17: row = 40'h7F_08_08_08_7F;
			6'd18: row = 40'h00_41_7F_41_00;
			6'd19: row = 40'h20_40_41_3F_01;
			6'd20: row = 40'h7F_08_14_22_41;
			6'd21: row = 40'h7F_40_40_40_40;
			6'd22: row = 40'h7F_02_0C_02_7F;
			6'd23: row = 40'h7F_04_08_10_7F;
			6'd24: row = 40'h3E_41_41_41_3E;
			6'd25: row = 40'h7F_09_09_09_06;
			6'd26: row = 40'h3E_41_51_21_5E;
			6'd27: row = 40'h7F_09_19_29_46;
			6'd28: row = 40'h46_49_49_49_31;
			6'd29: row = 40'h01_01_7F_01_01;
			6'd30: row = 40'h3F_40_40_40_3F;
			6'd31: row = 40'h1F_20_40_20_1F;
			6'd32: row = 40'h3F_40_38_40_3F;
			6'd33: row = 40'h63_14_08_14_63;
			6'd34: row = 40'h03_04_78_04_03;
			6'd35: row = 40'h61_51_49_45_43;
			GL_COLON: row = 40'h00_36_36_00_00;
			GL_DASH:  row = 40'h08_08_08_08_08;
			GL_SPACE: row = 40'h00_00_00_00_00;
			default:  row = 40'h02_01_51_09_06;
		endcase
		case (col)
			3'd0:    c = row[39:32];
			3'd1:    c = row[31:24];
			3'd2:    c = row[23:16];
			3'd3:    c = row[15:8];
			3'd4:    c = row[7:0];
			default: c = BLANK_COL;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/otlr_if.sv]
// Valid/ready channel interfaces for text slots in and bus bytes out.
`default_nettype none
interface otlr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic [3:0] page;
	logic       first_slot;

	modport source (output valid, character, page, first_slot, input ready);
	modport sink   (input valid, character, page, first_slot, output ready);
endinterface

interface otlr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       start_before;
	logic       stop_after;
	logic       last;

	modport source (output valid, bus_byte, start_before, stop_after, last, input ready);
	modport sink   (input valid, bus_byte, start_before, stop_after, last, output ready);
endinterface
`default_nettype wire

[rtl/otlr_front.sv]
// Front end: line state, slot classification and cell command generation.
`default_nettype none
module otlr_front #(
	parameter int LINE_COLUMNS = otlr_pkg::LINE_COLUMNS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	otlr_in_if.sink                  txt,
	input  wire otlr_pkg::q_stat_t   q_stat,
	output logic                     push,
	output otlr_pkg::cell_cmd_t      cmd
);
	localparam int SUM_W = $clog2(LINE_COLUMNS + otlr_pkg::CELL_COLS);

	logic [SUM_W-1:0] begin_q;
	logic             ended_q;
	logic             dropped_q;

	logic             accept;
	logic             open_line;
	logic [SUM_W-1:0] begin_eff;
	logic [SUM_W-1:0] rem;
	logic [SUM_W-1:0] next_begin;
	logic             ended_eff;
	logic             final_c;
	logic             page_ok;

	assign txt.ready = !q_stat.full;
	assign accept    = txt.valid && txt.ready;
	assign page_ok   = txt.page <= 4'(otlr_pkg::MAX_PAGE);
	assign open_line = txt.first_slot ? page_ok : !dropped_q;
	assign begin_eff = txt.first_slot ? '0 : begin_q;
	assign ended_eff = (txt.first_slot ? 1'b0 : ended_q) || (txt.character == otlr_pkg::CH_NUL);
	assign rem       = SUM_W'(LINE_COLUMNS) - begin_eff;
	assign next_begin = begin_eff + SUM_W'(otlr_pkg::CELL_COLS);
	assign final_c   = next_begin >= SUM_W'(LINE_COLUMNS);

	assign push = accept && open_line;

	always_comb begin
		cmd.hdr     = txt.first_slot;
		cmd.page    = txt.page[2:0];
		cmd.glyph   = ended_eff ? otlr_pkg::GL_SPACE : otlr_pkg::glyph_code(txt.character);
		cmd.ncols   = (rem > SUM_W'(otlr_pkg::CELL_COLS)) ? 3'(otlr_pkg::CELL_COLS) : rem[2:0];
		cmd.final_c = final_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q   <= '0;
			ended_q   <= 1'b0;
			dropped_q <= 1'b1;
		end else if (accept) begin
			if (txt.first_slot && !page_ok) begin
				begin_q   <= '0;
				ended_q   <= 1'b0;
				dropped_q <= 1'b1;
			end else if (open_line) begin
				ended_q   <= ended_eff;
				dropped_q <= final_c;
				begin_q   <= final_c ? '0 : next_begin;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/otlr_queue.sv]
// Short FIFO of cell commands between the front and back ends.
`default_nettype none
module otlr_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire otlr_pkg::cell_cmd_t wr_cmd,
	input  wire logic                pop,
	output otlr_pkg::cell_cmd_t      head,
	output otlr_pkg::q_stat_t        stat,
	output logic [$clog2(otlr_pkg::QUEUE_DEPTH+1)-1:0] count
);
	localparam int DEPTH = otlr_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	otlr_pkg::cell_cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = count_q == CW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign head       = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

[rtl/otlr_back.sv]
// Back end: byte sequencer, font lookup and output register.
`default_nettype none
module otlr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire otlr_pkg::cell_cmd_t head,
	input  wire otlr_pkg::q_stat_t   q_stat,
	input  wire logic [7:0]          addr_byte,
	output logic                     pop,
	otlr_out_if.source               bus
);
	logic [4:0] idx_q;
	logic       ovalid_q;
	logic [7:0] byte_q;
	logic       start_q;
	logic       stop_q;
	logic       last_q;

	logic       emit;
	logic [4:0] eff;
	logic [2:0] k;
	logic       in_glyph;
	logic       glyph_last;
	logic [7:0] nbyte;
	logic       nstart;
	logic       nstop;
	logic       nlast;

	assign emit       = !q_stat.empty && (!ovalid_q || bus.ready);
	assign eff        = idx_q + (head.hdr ? 5'd0 : 5'(otlr_pkg::HDR_BYTES));
	assign k          = 3'(eff - 5'(otlr_pkg::HDR_BYTES));
	assign in_glyph   = eff >= 5'(otlr_pkg::HDR_BYTES);
	assign glyph_last = k == (head.ncols - 3'd1);
	assign nlast      = in_glyph && glyph_last;
	assign pop        = emit && nlast;

	// header: three command transactions then the data-mode header
	always_comb begin
		nstart = 1'b0;
		nstop  = 1'b0;
		unique case (eff) inside
			5'd0, 5'd3, 5'd6, 5'd9: begin
				nbyte  = addr_byte;
				nstart = 1'b1;
			end
			5'd1, 5'd4, 5'd7: nbyte = otlr_pkg::CTRL_CMD;
			5'd2: begin
				nbyte = otlr_pkg::PAGE_CMD + {5'd0, head.page};
				nstop = 1'b1;
			end
			5'd5: begin
				nbyte = otlr_pkg::COL_LO_CMD;
				nstop = 1'b1;
			end
			5'd8: begin
				nbyte = otlr_pkg::COL_HI_CMD;
				nstop = 1'b1;
			end
			5'd10: nbyte = otlr_pkg::CTRL_DATA;
			default: begin
				nbyte = otlr_pkg::font_column(head.glyph, k);
				nstop = head.final_c && glyph_last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit)
				idx_q <= nlast ? '0 : idx_q + 5'd1;
			if (emit)
				ovalid_q <= 1'b1;
			else if (bus.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= nbyte;
			start_q <= nstart;
			stop_q  <= nstop;
			last_q  <= nlast;
		end
	end

	assign bus.valid        = ovalid_q;
	assign bus.bus_byte     = byte_q;
	assign bus.start_before = start_q;
	assign bus.stop_after   = stop_q;
	assign bus.last         = last_q;
endmodule
`default_nettype wire

[rtl/oled_text_line_renderer_top.sv]
// Top level of the OLED text line renderer: front end, cell queue, back end.
//
// Turns one text character slot per input beat into the I2C byte stream for one
// page of a LINE_COLUMNS-wide display, one output beat per bus byte. A slot with
// first_slot set opens a line: 11 beats of positioning (page, column low, column
// high commands, then the data header) precede its first cell. Each cell gives
// six font columns (5x7 glyph plus a blank), except the cell that reaches the
// right edge, which may be cut short and carries the stop. Rate: one output beat per
// cycle while the bus is ready and a cell is queued. The front end accepts a slot
// whenever the two-entry cell queue has room, so input and output stall
// independently. Slots that produce nothing (page above 7, no line open) are
// accepted without pushing a cell. The user must write device_address_byte
// through cfg_we/cfg_wdata only while idle; the block itself does not enforce it.
`default_nettype none
module oled_text_line_renderer_top #(
	parameter int LINE_COLUMNS = otlr_pkg::LINE_COLUMNS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	otlr_in_if.sink         txt,
	otlr_out_if.source      bus,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	// device address byte (with write bit), sent after every start
	logic [7:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			addr_q <= otlr_pkg::ADDR_RESET;
		else if (cfg_we)
			addr_q <= cfg_wdata;
	end

	logic                 push;
	logic                 pop;
	otlr_pkg::cell_cmd_t  wr_cmd;
	otlr_pkg::cell_cmd_t  head;
	otlr_pkg::q_stat_t    q_stat;
	logic [$clog2(otlr_pkg::QUEUE_DEPTH+1)-1:0] q_count;

	// front: tracks the open line and turns each slot into a cell command
	otlr_front #(
		.LINE_COLUMNS(LINE_COLUMNS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.txt   (txt),
		.q_stat(q_stat),
		.push  (push),
		.cmd   (wr_cmd)
	);

	otlr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(wr_cmd),
		.pop   (pop),
		.head  (head),
		.stat  (q_stat),
		.count (q_count)
	);

	// back: walks header and glyph columns, one beat per cycle while the bus is ready
	otlr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.addr_byte(addr_q),
		.pop      (pop),
		.bus      (bus)
	);

	// queue never overfills or underflows
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= 2'(otlr_pkg::QUEUE_DEPTH))
		else $error("cell queue over depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty cell queue");

	// an address beat opens a transaction, never closes one or ends a slot
	a_start_beat: assert property (@(posedge clk) disable iff (!arst_n)
		bus.valid && bus.start_before |-> !bus.stop_after && !bus.last)
		else $error("start beat marked stop or last");
endmodule
`default_nettype wire
